>>> hdl/gcls_pkg.sv
// shared types, register indexes and widths for the gesture classifier
// no dependencies; imported by every module of the block
package gcls_pkg;

   // coordinate and register widths
   localparam int COORD_BITS = 10;
   localparam int TIME_BITS  = 32;
   localparam int MS_BITS    = 16;
   localparam int CFG_BITS   = 10;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LONG_PRESS   = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SHORT_PRESS  = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SWIPE_MIN    = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_HOLD_JITTER  = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SCREEN_WIDTH = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_HDR_HOLD     = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_HDR_TAP      = 3'd6;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TOUCH_EN     = 3'd7;

   // reset values
   localparam logic [MS_BITS-1:0]  RST_LONG_PRESS  = 16'd600;
   localparam logic [MS_BITS-1:0]  RST_SHORT_PRESS = 16'd500;
   localparam logic [CFG_BITS-1:0] RST_SWIPE_MIN   = 10'd30;
   localparam logic [CFG_BITS-1:0] RST_HOLD_JITTER = 10'd20;
   localparam logic [CFG_BITS-1:0] RST_THIRD       = 10'd106;
   localparam logic [CFG_BITS-1:0] RST_TWO_THIRD   = 10'd213;
   localparam logic [CFG_BITS-1:0] RST_HDR_HOLD    = 10'd40;
   localparam logic [CFG_BITS-1:0] RST_HDR_TAP     = 10'd30;

   // reciprocal of three, scaled by 2^13, good for values below 2048
   localparam int            THIRD_SHIFT = 13;
   localparam logic [11:0]   THIRD_RECIP = 12'd2731;

   typedef struct packed {
      logic                  btn_a_down;
      logic                  btn_b_down;
      logic                  touch_down;
      logic [COORD_BITS-1:0] touch_x;
      logic [COORD_BITS-1:0] touch_y;
      logic [TIME_BITS-1:0]  now_ms;
   } req_type;

   typedef struct packed {
      logic ev_next;
      logic ev_select;
      logic ev_previous;
      logic ev_exit;
      logic ev_show_ip;
   } rsp_type;

   // live configuration, with the tap thirds precomputed
   typedef struct packed {
      logic [MS_BITS-1:0]  long_ms;
      logic [MS_BITS-1:0]  short_ms;
      logic [CFG_BITS-1:0] swipe_min;
      logic [CFG_BITS-1:0] hold_jitter;
      logic [CFG_BITS-1:0] third;
      logic [CFG_BITS-1:0] two_third;
      logic [CFG_BITS-1:0] hdr_hold;
      logic [CFG_BITS-1:0] hdr_tap;
      logic                touch_en;
   } cfg_type;

   typedef struct packed {
      logic long_fire;
      logic short_fire;
   } btn_ev_type;

   typedef struct packed {
      logic nx;
      logic sel;
      logic prv;
      logic ext;
      logic sip;
   } touch_ev_type;

endpackage

>>> hdl/button_and_touch_gesture_classifier_core.sv
// Gesture classifier: turns poll samples of two buttons and a touch panel
// into one beat of event pulses per sample. Each sample beat is classified
// in the cycle it is accepted and its result beat appears on the next cycle;
// a new sample is taken every cycle as long as the result register is free
// or being emptied in the same cycle, so throughput is one sample per cycle.
// Configuration writes take effect on the next cycle and belong in idle
// periods. Depends on gcls_pkg and its submodules.
module button_and_touch_gesture_classifier_core
   import gcls_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_wr_en,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type      cfg;
   btn_ev_type   a_ev, b_ev;
   touch_ev_type touch_ev;
   logic         accept;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   // result register frees up when its beat is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   gcls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gcls_button u_btn_a (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .down     (req_data.btn_a_down),
      .now_ms   (req_data.now_ms),
      .long_ms  (cfg.long_ms),
      .short_ms (cfg.short_ms),
      .ev       (a_ev)
   );

   gcls_button u_btn_b (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .down     (req_data.btn_b_down),
      .now_ms   (req_data.now_ms),
      .long_ms  (cfg.long_ms),
      .short_ms (cfg.short_ms),
      .ev       (b_ev)
   );

   gcls_touch u_touch (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cfg    (cfg),
      .down   (req_data.touch_down),
      .x      (req_data.touch_x),
      .y      (req_data.touch_y),
      .now_ms (req_data.now_ms),
      .ev     (touch_ev)
   );

   // merge button and touch events into the result beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.ev_next     = b_ev.short_fire | touch_ev.nx;
         rsp_data_in.ev_select   = a_ev.short_fire | touch_ev.sel;
         rsp_data_in.ev_previous = touch_ev.prv;
         rsp_data_in.ev_exit     = b_ev.long_fire | touch_ev.ext;
         rsp_data_in.ev_show_ip  = a_ev.long_fire | touch_ev.sip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat present straight after reset");

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted sample produced no result beat");

   a_touch_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(touch_ev))
      else $error("touch tracker fired more than one gesture");

   a_click_on_release: assert property (@(posedge clock) disable iff (reset)
      accept && a_ev.short_fire |-> !req_data.btn_a_down)
      else $error("button a click while still pressed");
`endif

endmodule

>>> hdl/gcls_csr.sv
// configuration registers, including the precomputed screen thirds
// depends on gcls_pkg
module gcls_csr
   import gcls_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;
   logic [CFG_BITS:0]   width1;
   logic [CFG_BITS:0]   width2;
   logic [CFG_BITS+12:0] prod1;
   logic [CFG_BITS+12:0] prod2;

   // thirds of the written width by reciprocal multiply
   always_comb begin
      width1 = {1'b0, csr_wdata[CFG_BITS-1:0]};
      width2 = {csr_wdata[CFG_BITS-1:0], 1'b0};
      prod1  = (CFG_BITS+13)'(width1) * (CFG_BITS+13)'(THIRD_RECIP);
      prod2  = (CFG_BITS+13)'(width2) * (CFG_BITS+13)'(THIRD_RECIP);
   end

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            CSR_LONG_PRESS:   cfg_in.long_ms     = csr_wdata[MS_BITS-1:0];
            CSR_SHORT_PRESS:  cfg_in.short_ms    = csr_wdata[MS_BITS-1:0];
            CSR_SWIPE_MIN:    cfg_in.swipe_min   = csr_wdata[CFG_BITS-1:0];
            CSR_HOLD_JITTER:  cfg_in.hold_jitter = csr_wdata[CFG_BITS-1:0];
            CSR_SCREEN_WIDTH: begin
               cfg_in.third     = prod1[THIRD_SHIFT +: CFG_BITS];
               cfg_in.two_third = prod2[THIRD_SHIFT +: CFG_BITS];
            end
            CSR_HDR_HOLD:     cfg_in.hdr_hold    = csr_wdata[CFG_BITS-1:0];
            CSR_HDR_TAP:      cfg_in.hdr_tap     = csr_wdata[CFG_BITS-1:0];
            CSR_TOUCH_EN:     cfg_in.touch_en    = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_ms     <= RST_LONG_PRESS;
         cfg_ff.short_ms    <= RST_SHORT_PRESS;
         cfg_ff.swipe_min   <= RST_SWIPE_MIN;
         cfg_ff.hold_jitter <= RST_HOLD_JITTER;
         cfg_ff.third       <= RST_THIRD;
         cfg_ff.two_third   <= RST_TWO_THIRD;
         cfg_ff.hdr_hold    <= RST_HDR_HOLD;
         cfg_ff.hdr_tap     <= RST_HDR_TAP;
         cfg_ff.touch_en    <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/gcls_button.sv
// one button tracker: long press once while held, short click on release
// depends on gcls_pkg
module gcls_button
   import gcls_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 down,
   input  logic [TIME_BITS-1:0] now_ms,
   input  logic [MS_BITS-1:0]   long_ms,
   input  logic [MS_BITS-1:0]   short_ms,
   output btn_ev_type           ev
);

   logic                 held_ff, held_in;
   logic                 done_ff, done_in;
   logic [TIME_BITS-1:0] t0_ff, t0_in;
   logic [TIME_BITS-1:0] elapsed;

   // press, hold and release tracking
   always_comb begin
      held_in = held_ff;
      done_in = done_ff;
      t0_in   = t0_ff;
      ev      = '0;
      elapsed = now_ms - t0_ff;
      if (accept) begin
         if (down && !held_ff) begin
            held_in = 1'b1;
            t0_in   = now_ms;
            done_in = 1'b0;
         end else if (down) begin
            if (!done_ff && elapsed > TIME_BITS'(long_ms)) begin
               done_in      = 1'b1;
               ev.long_fire = 1'b1;
            end
         end else if (held_ff) begin
            held_in = 1'b0;
            if (!done_ff && elapsed < TIME_BITS'(short_ms)) begin
               ev.short_fire = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         done_ff <= 1'b0;
         t0_ff   <= '0;
      end else begin
         held_ff <= held_in;
         done_ff <= done_in;
         t0_ff   <= t0_in;
      end
   end

endmodule

>>> hdl/gcls_touch.sv
// touch contact tracker: long hold, swipe and tap classification
// depends on gcls_pkg
module gcls_touch
   import gcls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  cfg_type               cfg,
   input  logic                  down,
   input  logic [COORD_BITS-1:0] x,
   input  logic [COORD_BITS-1:0] y,
   input  logic [TIME_BITS-1:0]  now_ms,
   output touch_ev_type          ev
);

   localparam int CMP_BITS = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;

   logic                  active_ff, active_in;
   logic                  long_done_ff, long_done_in;
   logic [COORD_BITS-1:0] first_x_ff, first_x_in;
   logic [COORD_BITS-1:0] first_y_ff, first_y_in;
   logic [COORD_BITS-1:0] latest_x_ff, latest_x_in;
   logic [COORD_BITS-1:0] latest_y_ff, latest_y_in;
   logic [TIME_BITS-1:0]  time_ff, time_in;

   logic [TIME_BITS-1:0]    elapsed;
   logic signed [COORD_BITS:0] hdx, hdy, rdx, rdy, dsel;
   logic [COORD_BITS:0]     hax, hay, rax, ray;
   logic [CMP_BITS-1:0]     hmx, hmy, rmx, rmy, jit, smin;
   logic [CMP_BITS-1:0]     fx, fy, hdr_hold, hdr_tap, third, two_third;
   logic                    hold_still, quick, moved;

   // movement against the first point, for the hold and release checks
   always_comb begin
      elapsed = now_ms - time_ff;
      hdx  = $signed({1'b0, x}) - $signed({1'b0, first_x_ff});
      hdy  = $signed({1'b0, y}) - $signed({1'b0, first_y_ff});
      rdx  = $signed({1'b0, latest_x_ff}) - $signed({1'b0, first_x_ff});
      rdy  = $signed({1'b0, latest_y_ff}) - $signed({1'b0, first_y_ff});
      hax  = hdx[COORD_BITS] ? -hdx : hdx;
      hay  = hdy[COORD_BITS] ? -hdy : hdy;
      rax  = rdx[COORD_BITS] ? -rdx : rdx;
      ray  = rdy[COORD_BITS] ? -rdy : rdy;
      hmx  = CMP_BITS'(hax[COORD_BITS-1:0]);
      hmy  = CMP_BITS'(hay[COORD_BITS-1:0]);
      rmx  = CMP_BITS'(rax[COORD_BITS-1:0]);
      rmy  = CMP_BITS'(ray[COORD_BITS-1:0]);
      jit  = CMP_BITS'(cfg.hold_jitter);
      smin = CMP_BITS'(cfg.swipe_min);
      fx        = CMP_BITS'(first_x_ff);
      fy        = CMP_BITS'(first_y_ff);
      hdr_hold  = CMP_BITS'(cfg.hdr_hold);
      hdr_tap   = CMP_BITS'(cfg.hdr_tap);
      third     = CMP_BITS'(cfg.third);
      two_third = CMP_BITS'(cfg.two_third);
      hold_still = (hmx < jit) && (hmy < jit);
      quick      = elapsed < TIME_BITS'(cfg.short_ms);
      moved      = (rmx > smin) || (rmy > smin);
      dsel       = (rmx > rmy) ? rdx : rdy;
   end

   // contact state and gesture decision
   always_comb begin
      active_in    = active_ff;
      long_done_in = long_done_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      latest_x_in  = latest_x_ff;
      latest_y_in  = latest_y_ff;
      time_in      = time_ff;
      ev           = '0;
      if (accept && cfg.touch_en) begin
         if (down) begin
            latest_x_in = x;
            latest_y_in = y;
            if (!active_ff) begin
               active_in    = 1'b1;
               first_x_in   = x;
               first_y_in   = y;
               time_in      = now_ms;
               long_done_in = 1'b0;
            end else if (!long_done_ff && elapsed > TIME_BITS'(cfg.long_ms)
                         && hold_still) begin
               long_done_in = 1'b1;
               if (fy < hdr_hold) begin
                  ev.sip = 1'b1;
               end else begin
                  ev.ext = 1'b1;
               end
            end
         end else if (active_ff) begin
            active_in = 1'b0;
            if (!long_done_ff && quick) begin
               if (moved) begin
                  // swipe: sign of the dominant axis picks the direction
                  if (dsel[COORD_BITS] && CMP_BITS'(-dsel) > smin) begin
                     ev.nx = 1'b1;
                  end else if (!dsel[COORD_BITS] && CMP_BITS'(dsel) > smin) begin
                     ev.prv = 1'b1;
                  end
               end else if (fy < hdr_tap) begin
                  ev.sip = 1'b1;
               end else if (fx < third) begin
                  ev.prv = 1'b1;
               end else if (fx > two_third) begin
                  ev.nx = 1'b1;
               end else begin
                  ev.sel = 1'b1;
               end
            end
         end
      end
   end

   // coordinates and start time are only read while a contact is active
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         long_done_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         long_done_ff <= long_done_in;
      end
   end

   always_ff @(posedge clock) begin
      first_x_ff  <= first_x_in;
      first_y_ff  <= first_y_in;
      latest_x_ff <= latest_x_in;
      latest_y_ff <= latest_y_in;
      time_ff     <= time_in;
   end

endmodule

>>> dv/button_and_touch_gesture_classifier_core_test.sv
// self-checking testbench for the button and touch gesture classifier core
// needs gcls_pkg and button_and_touch_gesture_classifier_core from hdl
`timescale 1ns / 100ps

module button_and_touch_gesture_classifier_core_test;
   import gcls_pkg::*;

   localparam int NUM_REGS    = 8;
   localparam int PHASE_BEATS = 120;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int KEY_A       = 0;
   localparam int KEY_B       = 1;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

   typedef enum logic [1:0] {KEY_QUIET, KEY_LONG, KEY_CLICK} key_event_type;
   typedef enum logic [1:0] {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FREE} pace_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // beats waiting to be offered and pulses waiting to be seen
   req_type samples_pending [$];
   rsp_type events_due [$];

   pace_type pace = PACE_SLOW_SINK;
   int tx_gap_pct = 7;
   int rx_gap_pct = 70;
   int fails = 0;
   int beats_in = 0;
   int beats_out = 0;
   int pulses_seen = 0;
   int samples_made = 0;
   int settings_loaded = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   logic held_off = 1'b0;
   logic [31:0] stamp_ms = 32'd1000;
   logic [CSR_DATA_BITS-1:0] setting [NUM_REGS];

   // mirror of the live configuration
   logic [MS_BITS-1:0]  lim_long     = RST_LONG_PRESS;
   logic [MS_BITS-1:0]  lim_short    = RST_SHORT_PRESS;
   logic [CFG_BITS-1:0] lim_swipe    = RST_SWIPE_MIN;
   logic [CFG_BITS-1:0] lim_jitter   = RST_HOLD_JITTER;
   logic [CFG_BITS-1:0] lim_width    = 10'd320;
   logic [CFG_BITS-1:0] lim_hdr_hold = RST_HDR_HOLD;
   logic [CFG_BITS-1:0] lim_hdr_tap  = RST_HDR_TAP;
   logic                touch_on     = 1'b1;

   // mirror of the gesture state
   logic        key_held [2]  = '{1'b0, 1'b0};
   logic [31:0] key_t0 [2]    = '{32'd0, 32'd0};
   logic        key_fired [2] = '{1'b0, 1'b0};
   logic        contact_on    = 1'b0;
   logic        contact_fired = 1'b0;
   logic [31:0] contact_t0    = '0;
   logic [COORD_BITS-1:0] start_x = '0, start_y = '0, last_x = '0, last_y = '0;

   button_and_touch_gesture_classifier_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // one button: long hold fires once, a quick release without it clicks
   function automatic key_event_type key_step(input int k, input logic down,
                                              input logic [31:0] now);
      logic [31:0] held_ms;
      held_ms = now - key_t0[k];
      if (down && !key_held[k]) begin
         key_held[k]  = 1'b1;
         key_t0[k]    = now;
         key_fired[k] = 1'b0;
         return KEY_QUIET;
      end
      if (down) begin
         if (!key_fired[k] && held_ms > lim_long) begin
            key_fired[k] = 1'b1;
            return KEY_LONG;
         end
         return KEY_QUIET;
      end
      if (key_held[k]) begin
         key_held[k] = 1'b0;
         if (!key_fired[k] && held_ms < lim_short)
            return KEY_CLICK;
      end
      return KEY_QUIET;
   endfunction

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // event pulses caused by one poll beat, advancing the mirrored state
   function automatic rsp_type gesture_events(input req_type s);
      rsp_type ev;
      key_event_type ka, kb;
      logic [31:0] held_ms;
      int dx, dy, ax, ay, sw, d;
      int unsigned third, two_third;
      logic quick;
      ev = '0;
      ka = key_step(KEY_A, s.btn_a_down, s.now_ms);
      kb = key_step(KEY_B, s.btn_b_down, s.now_ms);
      if (ka == KEY_LONG) ev.ev_show_ip = 1'b1;
      else if (ka == KEY_CLICK) ev.ev_select = 1'b1;
      if (kb == KEY_LONG) ev.ev_exit = 1'b1;
      else if (kb == KEY_CLICK) ev.ev_next = 1'b1;
      if (touch_on) begin
         held_ms = s.now_ms - contact_t0;
         if (s.touch_down && !contact_on) begin
            contact_on    = 1'b1;
            start_x       = s.touch_x;
            start_y       = s.touch_y;
            last_x        = s.touch_x;
            last_y        = s.touch_y;
            contact_t0    = s.now_ms;
            contact_fired = 1'b0;
         end else if (s.touch_down) begin
            last_x = s.touch_x;
            last_y = s.touch_y;
            dx = int'(last_x) - int'(start_x);
            dy = int'(last_y) - int'(start_y);
            if (!contact_fired && held_ms > lim_long &&
                magnitude(dx) < int'(lim_jitter) && magnitude(dy) < int'(lim_jitter)) begin
               contact_fired = 1'b1;
               if (start_y < lim_hdr_hold) ev.ev_show_ip = 1'b1;
               else ev.ev_exit = 1'b1;
            end
         end else if (contact_on) begin
            contact_on = 1'b0;
            dx = int'(last_x) - int'(start_x);
            dy = int'(last_y) - int'(start_y);
            ax = magnitude(dx);
            ay = magnitude(dy);
            sw = int'(lim_swipe);
            quick = held_ms < lim_short;
            third = 32'(lim_width) / 3;
            two_third = (32'(lim_width) * 2) / 3;
            if (!contact_fired && quick) begin
               if (ax > sw || ay > sw) begin
                  // swipe: dominant axis decides, falls back to vertical on a tie
                  d = (ax > ay) ? dx : dy;
                  if (d < -sw) ev.ev_next = 1'b1;
                  else if (d > sw) ev.ev_previous = 1'b1;
               end else if (start_y < lim_hdr_tap) ev.ev_show_ip = 1'b1;
               else if (start_x < third) ev.ev_previous = 1'b1;
               else if (start_x > two_third) ev.ev_next = 1'b1;
               else ev.ev_select = 1'b1;
            end
         end
      end
      return ev;
   endfunction

   // sender: offers queued beats, predicts each one as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            events_due.push_back(gesture_events(req_data));
            beats_in++;
         end
         if (!req_valid || req_ready) begin
            if (samples_pending.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
               req_valid <= 1'b1;
               req_data  <= samples_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_pulse(input string name, input logic want, input logic got);
      if (want !== got) begin
         $error("%s mismatch: expected %0b, got %0b", name, want, got);
         fails++;
      end
   endtask

   // receiver: checks result beats in order and paces rsp_ready
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (events_due.size() == 0) begin
               $error("result beat with no sample outstanding: %b", rsp_data);
               fails++;
            end else begin
               want = events_due.pop_front();
               pulses_seen += $countones(rsp_data);
               check_pulse("ev_next", want.ev_next, rsp_data.ev_next);
               check_pulse("ev_select", want.ev_select, rsp_data.ev_select);
               check_pulse("ev_previous", want.ev_previous, rsp_data.ev_previous);
               check_pulse("ev_exit", want.ev_exit, rsp_data.ev_exit);
               check_pulse("ev_show_ip", want.ev_show_ip, rsp_data.ev_show_ip);
            end
         end
         if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (pace == PACE_FREE && !held_off && events_due.size() != 0) begin
            // long back-pressure so the core fills and stalls its input
            rsp_ready  <= 1'b0;
            stall_left <= HOLD_CYCLES - 1;
            held_off   <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_gap_pct);
         end
      end
   end

   // watchdog on cycles with no beat moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [CSR_DATA_BITS-1:0] reg_mask(input int idx);
      case (idx)
         CSR_LONG_PRESS, CSR_SHORT_PRESS: return 16'hFFFF;
         CSR_TOUCH_EN: return 16'h0001;
         default: return 16'h03FF;
      endcase
   endfunction

   // write every register, optionally with junk above each register's width
   task automatic program_settings(input logic junk);
      logic [CSR_DATA_BITS-1:0] wv, kept;
      for (int i = 0; i < NUM_REGS; i++) begin
         wv = setting[i];
         if (junk) wv = wv | (16'($urandom) & ~reg_mask(i));
         kept = wv & reg_mask(i);
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_addr  <= i[CSR_ADDR_BITS-1:0];
         csr_wdata <= wv;
         case (i)
            CSR_LONG_PRESS:   lim_long     = kept;
            CSR_SHORT_PRESS:  lim_short    = kept;
            CSR_SWIPE_MIN:    lim_swipe    = kept[CFG_BITS-1:0];
            CSR_HOLD_JITTER:  lim_jitter   = kept[CFG_BITS-1:0];
            CSR_SCREEN_WIDTH: lim_width    = kept[CFG_BITS-1:0];
            CSR_HDR_HOLD:     lim_hdr_hold = kept[CFG_BITS-1:0];
            CSR_HDR_TAP:      lim_hdr_tap  = kept[CFG_BITS-1:0];
            default:          touch_on     = kept[0];
         endcase
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_loaded++;
   endtask

   task automatic set_pace(input pace_type p);
      pace = p;
      case (p)
         PACE_SLOW_SINK:   begin tx_gap_pct = 7;  rx_gap_pct = 70; end
         PACE_SLOW_SOURCE: begin tx_gap_pct = 70; rx_gap_pct = 7;  end
         default:          begin tx_gap_pct = 0;  rx_gap_pct = 0;  end
      endcase
   endtask

   task automatic push_sample(input logic a, input logic b, input logic td,
                              input int x, input int y, input logic [31:0] now);
      req_type s;
      s.btn_a_down = a;
      s.btn_b_down = b;
      s.touch_down = td;
      s.touch_x    = (x < 0) ? '0 : (x > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0] :
                     COORD_BITS'(x);
      s.touch_y    = (y < 0) ? '0 : (y > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0] :
                     COORD_BITS'(y);
      s.now_ms     = now;
      samples_pending.push_back(s);
      samples_made++;
   endtask

   // press one button for dur ms over n down beats, then release
   task automatic add_press(input int which, input int unsigned dur, input int n);
      logic [31:0] t0;
      t0 = stamp_ms;
      for (int i = 0; i < n; i++)
         push_sample(which == KEY_A, which == KEY_B, 1'b0, $urandom_range(COORD_MAX),
                     $urandom_range(COORD_MAX), t0 + 32'(dur * i / n));
      push_sample(1'b0, 1'b0, 1'b0, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                  t0 + dur);
      stamp_ms = t0 + dur + $urandom_range(1, 200);
   endtask

   // contact moving linearly by (dx, dy) over n beats, released after dur ms
   task automatic add_touch(input int x0, input int y0, input int dx, input int dy,
                            input int unsigned dur, input int n);
      logic [31:0] t0;
      int span;
      t0 = stamp_ms;
      span = (n > 1) ? n - 1 : 1;
      for (int i = 0; i < n; i++)
         push_sample(1'b0, 1'b0, 1'b1, x0 + dx * i / span, y0 + dy * i / span,
                     t0 + 32'(dur * i / n));
      push_sample(1'b0, 1'b0, 1'b0, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                  t0 + dur);
      stamp_ms = t0 + dur + $urandom_range(1, 200);
   endtask

   // hold times clustered around the short and long thresholds
   function automatic int unsigned pick_hold();
      int v;
      case ($urandom_range(4))
         0: v = $urandom_range(0, lim_short);
         1: v = int'(lim_short) + int'($urandom_range(2)) - 1;
         2: v = int'(lim_long) + int'($urandom_range(2)) - 1;
         3: v = 2 * int'(lim_long) + int'($urandom_range(1, 500));
         default: v = $urandom_range(0, 3 * int'(lim_long) + 1000);
      endcase
      return (v < 0) ? 0 : v;
   endfunction

   // movement clustered around a threshold, either sign
   function automatic int pick_offset(input int thr);
      int v;
      case ($urandom_range(4))
         0: v = 0;
         1: v = thr - 1;
         2: v = thr;
         3: v = thr + 1;
         default: v = $urandom_range(0, 3 * thr + 10);
      endcase
      if (v < 0) v = 0;
      return $urandom_range(1) ? -v : v;
   endfunction

   task automatic random_samples(input int count);
      int target, pick, thr, hdr, x0, y0;
      logic [31:0] now;
      target = samples_made + count;
      while (samples_made < target) begin
         pick = $urandom_range(9);
         if (pick < 3) begin
            add_press($urandom_range(KEY_B), pick_hold(), $urandom_range(1, 5));
         end else if (pick < 8) begin
            thr = $urandom_range(1) ? int'(lim_swipe) : int'(lim_jitter);
            hdr = (lim_hdr_hold > lim_hdr_tap) ? lim_hdr_hold : lim_hdr_tap;
            x0 = $urandom_range(3) ? $urandom_range(0, lim_width) : $urandom_range(COORD_MAX);
            y0 = $urandom_range(1) ? $urandom_range(0, 2 * hdr + 20) : $urandom_range(COORD_MAX);
            add_touch(x0, y0, pick_offset(thr), pick_offset(thr), pick_hold(),
                      $urandom_range(1, 5));
         end else begin
            // noise: arbitrary levels and occasionally a wild timestamp
            repeat ($urandom_range(1, 3)) begin
               now = ($urandom_range(3) == 0) ? $urandom : stamp_ms + $urandom_range(0, 50);
               push_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)),
                           $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), now);
               stamp_ms = now;
            end
         end
      end
   endtask

   // wait until every beat is sent and answered, then let the pipe settle
   task automatic drain();
      while (samples_pending.size() != 0 || req_valid || events_due.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic run_phase(input pace_type p, input logic junk);
      set_pace(p);
      program_settings(junk);
      random_samples(PHASE_BEATS);
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_pace(PACE_SLOW_SINK);

      // directed beats at reset configuration
      add_press(KEY_A, 100, 1);
      add_press(KEY_A, 1400, 2);
      add_press(KEY_B, 100, 1);
      add_press(KEY_B, 1400, 2);
      add_press(KEY_B, 550, 1);
      add_touch(160, 10, 0, 0, 100, 1);
      add_touch(160, 100, 0, 0, 100, 1);
      add_touch(200, 100, -60, 5, 200, 2);
      add_touch(100, 100, 5, 60, 200, 2);
      add_touch(160, 200, 2, 2, 1400, 2);
      push_sample(1'b1, 1'b1, 1'b1, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
      push_sample(1'b0, 1'b0, 1'b0, 0, 0, 32'h0000_0000);
      stamp_ms = 32'd5000;
      random_samples(PHASE_BEATS);
      drain();

      // every limit at its minimum, with a screen width of 1
      setting[CSR_LONG_PRESS]   = 16'd0;
      setting[CSR_SHORT_PRESS]  = 16'd0;
      setting[CSR_SWIPE_MIN]    = 16'd0;
      setting[CSR_HOLD_JITTER]  = 16'd0;
      setting[CSR_SCREEN_WIDTH] = 16'd1;
      setting[CSR_HDR_HOLD]     = 16'd0;
      setting[CSR_HDR_TAP]      = 16'd0;
      setting[CSR_TOUCH_EN]     = 16'd1;
      run_phase(PACE_SLOW_SINK, 1'b0);

      // every limit at its maximum
      setting[CSR_LONG_PRESS]   = 16'hFFFF;
      setting[CSR_SHORT_PRESS]  = 16'hFFFF;
      setting[CSR_SWIPE_MIN]    = 16'd1023;
      setting[CSR_HOLD_JITTER]  = 16'd1023;
      setting[CSR_SCREEN_WIDTH] = 16'd1023;
      setting[CSR_HDR_HOLD]     = 16'd1023;
      setting[CSR_HDR_TAP]      = 16'd1023;
      run_phase(PACE_SLOW_SOURCE, 1'b0);

      // touch ignored, state frozen mid-contact if one is open
      setting[CSR_LONG_PRESS]   = 16'($urandom_range(50, 2000));
      setting[CSR_SHORT_PRESS]  = 16'($urandom_range(50, 2000));
      setting[CSR_SWIPE_MIN]    = 16'($urandom_range(0, 100));
      setting[CSR_HOLD_JITTER]  = 16'($urandom_range(0, 100));
      setting[CSR_SCREEN_WIDTH] = 16'($urandom_range(1, 1023));
      setting[CSR_HDR_HOLD]     = 16'($urandom_range(0, 200));
      setting[CSR_HDR_TAP]      = 16'($urandom_range(0, 200));
      setting[CSR_TOUCH_EN]     = 16'd0;
      run_phase(PACE_SLOW_SOURCE, 1'b0);

      // random settings written with junk in the unused upper bits
      setting[CSR_LONG_PRESS]   = 16'($urandom_range(0, 3000));
      setting[CSR_SHORT_PRESS]  = 16'($urandom_range(0, 3000));
      setting[CSR_SWIPE_MIN]    = 16'($urandom_range(0, 150));
      setting[CSR_HOLD_JITTER]  = 16'($urandom_range(0, 150));
      setting[CSR_SCREEN_WIDTH] = 16'($urandom_range(1, 1023));
      setting[CSR_HDR_HOLD]     = 16'($urandom_range(0, 300));
      setting[CSR_HDR_TAP]      = 16'($urandom_range(0, 300));
      setting[CSR_TOUCH_EN]     = 16'd1;
      run_phase(PACE_FREE, 1'b1);

      // near-default settings with the timestamp about to wrap
      setting[CSR_LONG_PRESS]   = 16'($urandom_range(300, 900));
      setting[CSR_SHORT_PRESS]  = 16'($urandom_range(200, 700));
      setting[CSR_SWIPE_MIN]    = 16'($urandom_range(10, 60));
      setting[CSR_HOLD_JITTER]  = 16'($urandom_range(5, 40));
      setting[CSR_SCREEN_WIDTH] = 16'($urandom_range(200, 480));
      setting[CSR_HDR_HOLD]     = 16'($urandom_range(20, 60));
      setting[CSR_HDR_TAP]      = 16'($urandom_range(20, 60));
      stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      run_phase(PACE_FREE, 1'b0);

      $display("gesture core: %0d poll beats in, %0d result beats out, %0d pulses checked",
               beats_in, beats_out, pulses_seen);
      $display("covered reset values plus %0d register settings incl. both extremes and touch off",
               settings_loaded);
      if (fails == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> button_and_touch_gesture_classifier_core.f
hdl/gcls_pkg.sv
hdl/gcls_csr.sv
hdl/gcls_button.sv
hdl/gcls_touch.sv
hdl/button_and_touch_gesture_classifier_core.sv
dv/button_and_touch_gesture_classifier_core_test.sv
